/* rtl/dalpq_pkg.sv */
// Shared types and constants of the age-limited packet queue.
package dalpq_pkg;

  localparam int ID_W      = 32;
  localparam int TIME_W    = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int LIMIT_W   = 7;
  localparam int CNT_OUT_W = 7;
  localparam int STATUS_W  = 3;
  localparam int ENTRY_W   = ID_W + TIME_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_EMPTY     = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_HELD      = 3'd2,
    ST_PUSHED    = 3'd3,
    ST_EVICTED   = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 2'd0,
    REG_DROP_OLDEST = 2'd1,
    REG_MIN_DELAY   = 2'd2,
    REG_MAX_AGE     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVICT,
    S_CHECK
  } state_t;

endpackage

/* rtl/dalpq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dalpq_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/delay_age_limited_packet_queue_top.sv */
// Top level of the timestamped packet queue with hold time and age drop.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low. cmd 0 pushes packet_id stamped with now; cmd 1 pops. Every request
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall, so results must be captured when done is high.
// Order: a plain push, a rejected push and a pop of an empty queue give
// their result in the cycle after acceptance. A full drop-oldest push passes
// through S_EVICT, since the head entry is read from the RAM first. A pop
// stays in S_CHECK while stale heads are discarded: the ring RAM read port
// walks one head per cycle and each read data word is registered.
// A new request can be accepted in the cycle that shows the previous result.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are to be made by the user only while the queue is idle; the block does not enforce it.
// Reset empties the queue and restores capacity_limit to 64, drop_oldest to
// 1 and both time limits to 0. RAM contents are not cleared; entries are only
// read after being written.
module delay_age_limited_packet_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [dalpq_pkg::ID_W-1:0]        packet_id,
  input  logic [dalpq_pkg::TIME_W-1:0]      now,
  input  logic                              cfg_we,
  input  logic [dalpq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dalpq_pkg::CFG_W-1:0]       cfg_data,
  output logic                              done,
  output logic [dalpq_pkg::STATUS_W-1:0]    status,
  output logic [dalpq_pkg::ID_W-1:0]        out_packet_id,
  output logic [dalpq_pkg::TIME_W-1:0]      out_arrival,
  output logic [dalpq_pkg::CNT_OUT_W-1:0]   stale_drops,
  output logic [dalpq_pkg::CNT_OUT_W-1:0]   occupancy
);

  import dalpq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int OW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  // Configuration registers
  logic [LIMIT_W-1:0] capacity_limit;
  logic               drop_oldest;
  logic [CFG_W-1:0]   min_delay;
  logic [CFG_W-1:0]   max_age;

  // Queue control
  state_t        state, state_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] stale_cnt, stale_cnt_next;
  logic [ID_W-1:0]   pid_r;
  logic [TIME_W-1:0] now_r;

  // RAM
  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  rd_arr;

  // Result staging
  logic              res_load;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [TIME_W-1:0] res_arr;
  logic [CW-1:0]     res_stale;
  logic [CW-1:0]     res_occ;
  logic [CW-1:0]     occ_r;
  logic [CW-1:0]     stale_r;

  logic              accept;
  logic [LW-1:0]     limit;
  logic              full;
  logic [PW-1:0]     head_inc;
  logic [PW-1:0]     tail_inc;
  logic [TIME_W:0]   hold_until;
  logic              held;
  logic [TIME_W-1:0] age;
  logic              too_old;
  logic [OW-1:0]     stale_wide;
  logic [OW-1:0]     occ_wide;

  dalpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head_next),
    .rdata(ram_rdata)
  );

  assign rd_id  = ram_rdata[ID_W-1:0];
  assign rd_arr = ram_rdata[ID_W +: TIME_W];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // A zero limit behaves as one; a limit beyond the ring size as the ring size.
  always_comb begin
    if (capacity_limit == '0) begin
      limit = LW'(1);
    end else if (LW'(capacity_limit) > LW'(DEPTH)) begin
      limit = LW'(DEPTH);
    end else begin
      limit = LW'(capacity_limit);
    end
  end

  assign full     = (LW'(count) >= limit);
  assign head_inc = (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;

  // Hold and age tests on the head entry read from the RAM.
  assign hold_until = {1'b0, rd_arr} + (TIME_W + 1)'(min_delay);
  assign held       = (min_delay != '0) && ({1'b0, now_r} < hold_until);
  assign age        = (now_r > rd_arr) ? (now_r - rd_arr) : '0;
  assign too_old    = (max_age != '0) && (age > TIME_W'(max_age));

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    stale_cnt_next = stale_cnt;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_wdata      = {now, packet_id};
    res_load       = 1'b0;
    res_status     = ST_EMPTY;
    res_id         = '0;
    res_arr        = '0;
    res_stale      = '0;
    res_occ        = count;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!cmd) begin
            if (full && drop_oldest) begin
              state_next = S_EVICT;
            end else if (full) begin
              res_load   = 1'b1;
              res_status = ST_REJECTED;
              res_id     = packet_id;
            end else begin
              ram_we     = 1'b1;
              tail_next  = tail_inc;
              count_next = count + 1'b1;
              res_load   = 1'b1;
              res_status = ST_PUSHED;
              res_occ    = count + 1'b1;
            end
          end else begin
            stale_cnt_next = '0;
            if (count == '0) begin
              res_load   = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              state_next = S_CHECK;
            end
          end
        end
      end
      S_EVICT: begin
        // The head was read in the accept cycle; the tail write lands after
        // the read, so a completely full ring is safe.
        ram_we     = 1'b1;
        ram_wdata  = {now_r, pid_r};
        head_next  = head_inc;
        tail_next  = tail_inc;
        res_load   = 1'b1;
        res_status = ST_EVICTED;
        res_id     = rd_id;
        res_arr    = rd_arr;
        state_next = S_IDLE;
      end
      S_CHECK: begin
        if (held) begin
          res_load   = 1'b1;
          res_status = ST_HELD;
          res_stale  = stale_cnt;
          state_next = S_IDLE;
        end else begin
          head_next  = head_inc;
          count_next = count - 1'b1;
          if (too_old) begin
            stale_cnt_next = stale_cnt + 1'b1;
            if (count == CW'(1)) begin
              res_load   = 1'b1;
              res_status = ST_EMPTY;
              res_stale  = stale_cnt + 1'b1;
              res_occ    = '0;
              state_next = S_IDLE;
            end
          end else begin
            res_load   = 1'b1;
            res_status = ST_DELIVERED;
            res_id     = rd_id;
            res_arr    = rd_arr;
            res_stale  = stale_cnt;
            res_occ    = count - 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      stale_cnt <= '0;
      done      <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      stale_cnt <= stale_cnt_next;
      done      <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pid_r <= packet_id;
      now_r <= now;
    end
    if (res_load) begin
      status        <= res_status;
      out_packet_id <= res_id;
      out_arrival   <= res_arr;
      stale_r       <= res_stale;
      occ_r         <= res_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_W'(64);
      drop_oldest    <= 1'b1;
      min_delay      <= '0;
      max_age        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAPACITY:    capacity_limit <= cfg_data[LIMIT_W-1:0];
        REG_DROP_OLDEST: drop_oldest    <= cfg_data[0];
        REG_MIN_DELAY:   min_delay      <= cfg_data;
        REG_MAX_AGE:     max_age        <= cfg_data;
      endcase
    end
  end

  assign stale_wide  = OW'(stale_r);
  assign occ_wide    = OW'(occ_r);
  assign stale_drops = stale_wide[CNT_OUT_W-1:0];
  assign occupancy   = occ_wide[CNT_OUT_W-1:0];

  // The entry count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= LW'(DEPTH))
    else $error("entry count exceeds ring depth");

  // Head and tail meet only when the ring is empty or completely full.
  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (head == tail) == ((count == '0) || (LW'(count) == LW'(DEPTH))))
    else $error("ring pointers disagree with entry count");

  // A result is only presented once the request has finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while a request is still in progress");

  // A pop of an empty queue answers in the next cycle with the empty status.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd && (count == '0)) |=> (done && (status == ST_EMPTY)))
    else $error("pop of empty queue did not report empty");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the timestamped packet queue with hold time and age drop.
module testbench;
  import dalpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  typedef struct {
    logic              cmd;
    logic [ID_W-1:0]   packet_id;
    logic [TIME_W-1:0] now;
  } queue_req_t;

  typedef struct {
    status_t              st;
    logic [ID_W-1:0]      id;
    logic [TIME_W-1:0]    arr;
    logic [CNT_OUT_W-1:0] stale;
    logic [CNT_OUT_W-1:0] occ;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cmd = CMD_PUSH;
  logic [ID_W-1:0] packet_id = '0;
  logic [TIME_W-1:0] now = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0] out_packet_id;
  logic [TIME_W-1:0] out_arrival;
  logic [CNT_OUT_W-1:0] stale_drops;
  logic [CNT_OUT_W-1:0] occupancy;

  // Shadow copy of the queue and its registers.
  logic [ID_W-1:0] shadow_ids [DEPTH];
  logic [TIME_W-1:0] shadow_stamps [DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;
  int unsigned shadow_count = 0;
  logic [LIMIT_W-1:0] limit_reg = 7'd64;
  logic drop_reg = 1'b1;
  logic [31:0] hold_reg = '0;
  logic [31:0] age_reg = '0;

  queue_req_t request_backlog[$];
  queue_result_t awaited_results[$];
  queue_req_t req_on_bus;
  int open_requests = 0;
  int idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  delay_age_limited_packet_queue_top #(.DEPTH(DEPTH)) dut (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void store_tail(logic [ID_W-1:0] id, logic [TIME_W-1:0] stamp);
    shadow_ids[shadow_tail] = id;
    shadow_stamps[shadow_tail] = stamp;
    shadow_tail = (shadow_tail + 1) % DEPTH;
    shadow_count++;
  endfunction

  function automatic queue_result_t next_queue_result(queue_req_t r);
    queue_result_t o;
    int unsigned lim;
    int unsigned stale;
    logic [63:0] age;
    logic [ID_W-1:0] hid;
    logic [TIME_W-1:0] harr;
    logic walking;
    o.st = ST_EMPTY;
    o.id = '0;
    o.arr = '0;
    stale = 0;
    if (r.cmd == CMD_PUSH) begin
      lim = limit_reg;
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      if (shadow_count >= lim) begin
        if (drop_reg) begin
          // The head goes even when it is still inside its hold time.
          o.id = shadow_ids[shadow_head];
          o.arr = shadow_stamps[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
          store_tail(r.packet_id, r.now);
          o.st = ST_EVICTED;
        end else begin
          o.id = r.packet_id;
          o.st = ST_REJECTED;
        end
      end else begin
        store_tail(r.packet_id, r.now);
        o.st = ST_PUSHED;
      end
    end else begin
      walking = 1'b1;
      while (walking) begin
        if (shadow_count == 0) begin
          o.st = ST_EMPTY;
          walking = 1'b0;
        end else if (hold_reg != 0 &&
                     64'(r.now) < 64'(shadow_stamps[shadow_head]) + 64'(hold_reg)) begin
          o.st = ST_HELD;
          walking = 1'b0;
        end else begin
          hid = shadow_ids[shadow_head];
          harr = shadow_stamps[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
          // A stamp later than now counts as age zero.
          age = (r.now >= harr) ? 64'(r.now) - 64'(harr) : 64'd0;
          if (age_reg != 0 && age > 64'(age_reg)) begin
            stale++;
          end else begin
            o.st = ST_DELIVERED;
            o.id = hid;
            o.arr = harr;
            walking = 1'b0;
          end
        end
      end
    end
    o.stale = CNT_OUT_W'(stale);
    o.occ = CNT_OUT_W'(shadow_count);
    return o;
  endfunction

  // Driver: one request on the bus at a time, held until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) awaited_results.push_back(next_queue_result(req_on_bus));
      if (!start || !busy) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req_on_bus = request_backlog.pop_front();
          start <= 1'b1;
          cmd <= req_on_bus.cmd;
          packet_id <= req_on_bus.packet_id;
          now <= req_on_bus.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: results cannot be held off, so each strobe is checked as it comes.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", 64'(want.st), 64'(status));
        compare_field("out_packet_id", 64'(want.id), 64'(out_packet_id));
        compare_field("out_arrival", 64'(want.arr), 64'(out_arrival));
        compare_field("stale_drops", 64'(want.stale), 64'(stale_drops));
        compare_field("occupancy", 64'(want.occ), 64'(occupancy));
        open_requests--;
      end
    end
  end

  task automatic add_request(logic c, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
    queue_req_t r;
    r.cmd = c;
    r.packet_id = id;
    r.now = t;
    request_backlog.push_back(r);
    open_requests++;
  endtask

  task automatic drain();
    do @(posedge clk); while (open_requests != 0 || busy !== 1'b0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CAPACITY: limit_reg = val[LIMIT_W-1:0];
      REG_DROP_OLDEST: drop_reg = val[0];
      REG_MIN_DELAY: hold_reg = val;
      REG_MAX_AGE: age_reg = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [31:0] cap, logic [31:0] drop, logic [31:0] hold,
                              logic [31:0] max_age);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_DROP_OLDEST, drop);
    write_reg(REG_MIN_DELAY, hold);
    write_reg(REG_MAX_AGE, max_age);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    int roll;
    int push_pct;
    int step_max;
    logic [31:0] cap;
    logic [31:0] drop;
    logic [31:0] hold;
    logic [31:0] max_age;
    logic [TIME_W-1:0] tb_now;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 27;
    drain();

    // A zero limit acts as one, with extreme handles and stamps.
    apply_config(32'd0, 32'd1, 32'd0, 32'd0);
    add_request(CMD_PUSH, 32'hFFFF_FFFF, 48'd0);
    add_request(CMD_PUSH, 32'd0, 48'hFFFF_FFFF_FFFF);
    add_request(CMD_POP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_request(CMD_POP, 32'd0, 48'hFFFF_FFFF_FFFF);
    drain();

    // A limit above the depth, a hold time, and a pop at a time before arrival.
    apply_config(32'd127, 32'd0, 32'd10, 32'd0);
    add_request(CMD_PUSH, 32'd1, 48'd100);
    add_request(CMD_PUSH, 32'd2, 48'd101);
    add_request(CMD_PUSH, 32'd3, 48'd102);
    add_request(CMD_POP, 32'd0, 48'd105);
    add_request(CMD_POP, 32'd0, 48'd110);
    add_request(CMD_POP, 32'd0, 48'd90);
    drain();

    // Limit lowered below occupancy: reject, then evict a held head.
    apply_config(32'd1, 32'd0, 32'd10, 32'd0);
    add_request(CMD_PUSH, 32'd4, 48'd120);
    drain();
    apply_config(32'd1, 32'd1, 32'd1000, 32'd0);
    add_request(CMD_PUSH, 32'd6, 48'd121);
    drain();

    // Stale heads ahead of a held one, an empty queue after discards, then delivery.
    apply_config(32'd64, 32'd1, 32'd5, 32'd8);
    add_request(CMD_PUSH, 32'd7, 48'd200);
    add_request(CMD_POP, 32'd0, 48'd130);
    add_request(CMD_POP, 32'd0, 48'd500);
    add_request(CMD_PUSH, 32'd8, 48'd600);
    add_request(CMD_POP, 32'd0, 48'd606);
    drain();

    // With no hold time, a head stamped later than now is delivered at age zero.
    apply_config(32'd64, 32'd1, 32'd0, 32'd8);
    add_request(CMD_PUSH, 32'd9, 48'd1000);
    add_request(CMD_POP, 32'd0, 48'd990);
    drain();

    for (ph = 0; ph < 24; ph++) begin
      idle_pct = (ph < 8) ? 27 : ((ph < 16) ? 52 : 0);
      case ($urandom_range(7))
        0: cap = 32'd0;
        1: cap = 32'd1;
        2: cap = 32'd64;
        3: cap = $urandom_range(65, 127);
        4: cap = $urandom;
        default: cap = $urandom_range(2, 8);
      endcase
      drop = $urandom;
      case ($urandom_range(9))
        0, 1, 2: hold = 32'd0;
        8: hold = 32'hFFFF_FFFF;
        9: hold = $urandom;
        default: hold = $urandom_range(1, 30);
      endcase
      case ($urandom_range(9))
        0, 1, 2: max_age = 32'd0;
        3: max_age = 32'd1;
        8: max_age = 32'hFFFF_FFFF;
        9: max_age = $urandom;
        default: max_age = $urandom_range(2, 60);
      endcase
      apply_config(cap, drop, hold, max_age);

      push_pct = $urandom_range(35, 75);
      step_max = $urandom_range(0, 12);
      case ($urandom_range(3))
        0: tb_now = '0;
        1: tb_now = 48'hFFFF_FFFF_FF80;
        default: tb_now = 48'({$urandom, $urandom});
      endcase
      for (n = 0; n < 50; n++) begin
        roll = $urandom_range(99);
        // Mostly small steps, now and then a large jump that ages the whole queue,
        // and rarely a step back in time.
        if (roll < 2) tb_now = tb_now - 48'($urandom_range(0, 20));
        else if (roll < 5) tb_now = tb_now + 48'($urandom);
        else tb_now = tb_now + 48'($urandom_range(0, step_max));
        add_request(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, $urandom, tb_now);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
